[sv/rsd_pkg.sv]
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared constants for the radial stick deadzone pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rsd_pkg;

  // fixed point: 16384 is 1.0
  localparam int FRAC_W   = 14;
  localparam int ONE_Q    = 16384;
  localparam int AXIS_MAX = 16384;

  // deadzone register, units of 1/4096, scaled by 4 to reach q14
  localparam int DZ_W     = 12;
  localparam int DQ_W     = DZ_W + 2;

  // raw sample fields and result fields
  localparam int RAW_W    = 8;
  localparam int AXIS_W   = 16;

  // radius: sqrt of a 30-bit radicand gives 15 bits
  localparam int SQ_SUM_W = 16;
  localparam int SQ_IN_W  = SQ_SUM_W + FRAC_W;
  localparam int R_W      = 15;

  // rescaled radius, saturated to 22 bits
  localparam int NR_W     = 22;
  localparam int DIV1_NUM_W = R_W + FRAC_W;

  // per-axis quotient
  localparam int PROD_W   = RAW_W + NR_W;
  localparam int DIV2_NUM_W = PROD_W + 7;
  localparam int M_W      = 15;

  // iterations of a shared step handled per pipeline stage
  localparam int STEPS    = 4;

endpackage

`default_nettype wire

[sv/rsd_if.sv]
// ----------------------------------------------------------------------------
// rsd_if
// Valid/ready channels for stick samples and rescaled axis results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsd_samp_if;
  logic       valid;
  logic       ready;
  logic [7:0] stick_x;
  logic [7:0] stick_y;
  logic [7:0] trigger_right;
  logic [7:0] trigger_left;

  modport src (output valid, stick_x, stick_y, trigger_right, trigger_left, input ready);
  modport snk (input valid, stick_x, stick_y, trigger_right, trigger_left, output ready);
endinterface

interface rsd_axes_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;

  modport src (output valid, axis_x, axis_y, axis_z, input ready);
  modport snk (input valid, axis_x, axis_y, axis_z, output ready);
endinterface

`default_nettype wire

[sv/radial_stick_deadzone.sv]
// ----------------------------------------------------------------------------
// radial_stick_deadzone
// Radial deadzone rescaling of a stick sample plus trigger difference axis.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while the result channel accepts, and returns one
// result per sample; the whole pipeline advances together, so a stall on the
// result channel holds every stage and deasserts samp.ready. Its main parts are
// the square root (5 stages), the radius rescale divider (7 stages) and
// the per-axis divider (5 stages), each resolving four bits per stage.
// Results are in q14 (16384 is 1.0): stick axes are zero inside the deadzone
// or at dead centre, otherwise rescaled so the deadzone edge maps to 0 and
// full deflection to 1.0, saturated to +-1.0. axis_z is
// (trigger_right - trigger_left) / 255. Write the deadzone register only
// while no request is in flight.
`default_nettype none

module radial_stick_deadzone (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata,
  rsd_samp_if.snk          samp,
  rsd_axes_if.src          axes
);

  localparam int R_W    = rsd_pkg::R_W;
  localparam int NR_W   = rsd_pkg::NR_W;
  localparam int DQ_W   = rsd_pkg::DQ_W;
  localparam int AW     = rsd_pkg::AXIS_W;
  localparam int SB1_W  = 8 + 8 + AW;
  localparam int SB2_W  = SB1_W + 1 + R_W;
  localparam int SBX_W  = 1 + 1 + AW;

  // deadzone register
  logic [rsd_pkg::DZ_W-1:0] deadzone;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone <= '0;
    end else if (cfg_we) begin
      deadzone <= cfg_wdata;
    end
  end

  logic [DQ_W-1:0] dq;
  assign dq = {deadzone, 2'b00};

  // global advance: the output register frees or drains
  logic adv;
  logic out_vld;

  assign adv        = !out_vld || axes.ready;
  assign samp.ready = adv;

  // stage 1: center, square, trigger difference
  logic signed [7:0]  a_c, b_c;
  logic signed [15:0] pa, pb;
  logic [15:0]        ssum;
  logic signed [8:0]  dz;
  logic [8:0]         dz_abs;
  logic [7:0]         zm;
  logic [13:0]        zw;
  logic [15:0]        zt;
  logic [14:0]        zmag;
  logic signed [15:0] z_c;

  always_comb begin
    a_c    = signed'({~samp.stick_x[7], samp.stick_x[6:0]});
    b_c    = signed'({~samp.stick_y[7], samp.stick_y[6:0]});
    pa     = a_c * a_c;
    pb     = b_c * b_c;
    ssum   = unsigned'(pa) + unsigned'(pb);
    dz     = signed'({1'b0, samp.trigger_right}) - signed'({1'b0, samp.trigger_left});
    dz_abs = dz[8] ? unsigned'(-dz) : unsigned'(dz);
    zm     = dz_abs[7:0];
    // 16384/255 = 64 + 64/255; small divide by 255 via add and shift
    zw     = {zm, 6'b0};
    zt     = (16'(zw) + 16'd1 + 16'(zw >> 8)) >> 8;
    zmag   = 15'(zw) + 15'(zt[7:0]);
    z_c    = dz[8] ? -signed'(16'(zmag)) : signed'(16'(zmag));
  end

  logic               s1_vld;
  logic signed [7:0]  s1_a, s1_b;
  logic [15:0]        s1_sum;
  logic signed [15:0] s1_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= samp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a   <= a_c;
      s1_b   <= b_c;
      s1_sum <= ssum;
      s1_z   <= z_c;
    end
  end

  // radius in q14
  logic             sq_vld;
  logic [R_W-1:0]   r;
  logic [SB1_W-1:0] sq_sb;

  rsd_isqrt #(
    .IN_W  (rsd_pkg::SQ_IN_W),
    .R_W   (R_W),
    .SB_W  (SB1_W),
    .STEPS (rsd_pkg::STEPS)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s1_vld),
    .rad       ({s1_sum, rsd_pkg::FRAC_W'(0)}),
    .sb_in     ({s1_a, s1_b, s1_z}),
    .out_valid (sq_vld),
    .root      (r),
    .sb_out    (sq_sb)
  );

  // rescaled radius nr = (r - dq) * 1.0 / (1.0 - dq)
  logic [R_W-1:0]  r_less;
  logic [R_W-1:0]  den1;
  logic            zero_c;

  assign r_less = r - R_W'(dq);
  assign den1   = R_W'(rsd_pkg::ONE_Q) - R_W'(dq);
  assign zero_c = (r == '0) || (r < R_W'(dq));

  logic             d1_vld;
  logic [NR_W-1:0]  nr;
  logic [SB2_W-1:0] d1_sb;

  rsd_div #(
    .NUM_W (rsd_pkg::DIV1_NUM_W),
    .DEN_W (R_W),
    .Q_W   (NR_W),
    .SB_W  (SB2_W),
    .STEPS (rsd_pkg::STEPS)
  ) u_div_nr (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sq_vld),
    .num       ({r_less, rsd_pkg::FRAC_W'(0)}),
    .den       (den1),
    .sb_in     ({sq_sb, zero_c, r}),
    .out_valid (d1_vld),
    .quo       (nr),
    .sb_out    (d1_sb)
  );

  // per-axis product |q| * nr
  logic signed [7:0]  d1_a, d1_b;
  logic signed [15:0] d1_z;
  logic               d1_zero;
  logic [R_W-1:0]     d1_r;
  logic [8:0]         a_abs9, b_abs9;
  logic [7:0]         a_abs, b_abs;

  assign {d1_a, d1_b, d1_z, d1_zero, d1_r} = d1_sb;
  assign a_abs9 = d1_a[7] ? 9'(-10'(d1_a)) : 9'(d1_a);
  assign b_abs9 = d1_b[7] ? 9'(-10'(d1_b)) : 9'(d1_b);
  assign a_abs  = a_abs9[7:0];
  assign b_abs  = b_abs9[7:0];

  logic                       m_vld;
  logic [rsd_pkg::PROD_W-1:0] m_px, m_py;
  logic [R_W-1:0]             m_r;
  logic                       m_zero, m_sx, m_sy;
  logic signed [15:0]         m_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (adv) begin
      m_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_px   <= a_abs * nr;
      m_py   <= b_abs * nr;
      m_r    <= d1_r;
      m_zero <= d1_zero;
      m_sx   <= d1_a[7];
      m_sy   <= d1_b[7];
      m_z    <= d1_z;
    end
  end

  // axis magnitude = |q| * nr / r
  logic                  dx_vld, dy_vld;
  logic [rsd_pkg::M_W-1:0] mx, my;
  logic [SBX_W-1:0]      dx_sb;
  logic                  dy_sx;

  rsd_div #(
    .NUM_W (rsd_pkg::DIV2_NUM_W),
    .DEN_W (R_W),
    .Q_W   (rsd_pkg::M_W),
    .SB_W  (SBX_W),
    .STEPS (rsd_pkg::STEPS)
  ) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (m_vld),
    .num       ({m_px, 7'b0}),
    .den       (m_r),
    .sb_in     ({m_zero, m_sx, m_z}),
    .out_valid (dx_vld),
    .quo       (mx),
    .sb_out    (dx_sb)
  );

  rsd_div #(
    .NUM_W (rsd_pkg::DIV2_NUM_W),
    .DEN_W (R_W),
    .Q_W   (rsd_pkg::M_W),
    .SB_W  (1),
    .STEPS (rsd_pkg::STEPS)
  ) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (m_vld),
    .num       ({m_py, 7'b0}),
    .den       (m_r),
    .sb_in     (m_sy),
    .out_valid (dy_vld),
    .quo       (my),
    .sb_out    (dy_sx)
  );

  // clamp, sign and deadzone select
  logic               f_zero, f_sx;
  logic signed [15:0] f_z;
  logic [15:0]        cx, cy;
  logic signed [15:0] ox_c, oy_c;

  always_comb begin
    {f_zero, f_sx, f_z} = dx_sb;
    cx = (16'(mx) > 16'(rsd_pkg::AXIS_MAX)) ? 16'(rsd_pkg::AXIS_MAX) : 16'(mx);
    cy = (16'(my) > 16'(rsd_pkg::AXIS_MAX)) ? 16'(rsd_pkg::AXIS_MAX) : 16'(my);
    ox_c = f_sx  ? -signed'(cx) : signed'(cx);
    oy_c = dy_sx ? -signed'(cy) : signed'(cy);
    if (f_zero) begin
      ox_c = '0;
      oy_c = '0;
    end
  end

  // output register
  logic signed [15:0] o_x, o_y, o_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= dx_vld && dy_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_x <= ox_c;
      o_y <= oy_c;
      o_z <= f_z;
    end
  end

  assign axes.valid  = out_vld;
  assign axes.axis_x = o_x;
  assign axes.axis_y = o_y;
  assign axes.axis_z = o_z;

endmodule

`default_nettype wire

[sv/rsd_isqrt.sv]
// ----------------------------------------------------------------------------
// rsd_isqrt
// Pipelined digit-by-digit integer square root, STEPS result bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_isqrt #(
  parameter int IN_W  = 30,
  parameter int R_W   = 15,
  parameter int SB_W  = 1,
  parameter int STEPS = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire logic            in_valid,
  input  wire logic [IN_W-1:0] rad,
  input  wire logic [SB_W-1:0] sb_in,
  output logic                 out_valid,
  output logic [R_W-1:0]       root,
  output logic [SB_W-1:0]      sb_out
);

  localparam int NS = (R_W + STEPS - 1) / STEPS;

  logic            vld  [NS+1];
  logic [R_W:0]    rem  [NS+1];
  logic [R_W-1:0]  rt   [NS+1];
  logic [IN_W-1:0] rd   [NS+1];
  logic [SB_W-1:0] sb   [NS+1];

  // entry register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= '0;
      rt[0]  <= '0;
      rd[0]  <= rad;
      sb[0]  <= sb_in;
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_stg
    logic [R_W:0]    rem_c;
    logic [R_W-1:0]  rt_c;
    logic [IN_W-1:0] rd_c;
    logic [R_W+2:0]  t;
    logic [R_W+2:0]  trial;

    // two radicand bits per result bit
    always_comb begin
      rem_c = rem[s-1];
      rt_c  = rt[s-1];
      rd_c  = rd[s-1];
      t     = '0;
      trial = '0;
      for (int j = 0; j < STEPS; j++) begin
        if ((s - 1) * STEPS + j < R_W) begin
          t     = {rem_c, rd_c[IN_W-1:IN_W-2]};
          trial = (R_W + 3)'({rt_c, 2'b01});
          rd_c  = rd_c << 2;
          if (t >= trial) begin
            t    = t - trial;
            rt_c = {rt_c[R_W-2:0], 1'b1};
          end else begin
            rt_c = {rt_c[R_W-2:0], 1'b0};
          end
          rem_c = t[R_W:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s] <= rem_c;
        rt[s]  <= rt_c;
        rd[s]  <= rd_c;
        sb[s]  <= sb[s-1];
      end
    end
  end

  assign out_valid = vld[NS];
  assign root      = rt[NS];
  assign sb_out    = sb[NS];

endmodule

`default_nettype wire

[sv/rsd_div.sv]
// ----------------------------------------------------------------------------
// rsd_div
// Pipelined restoring divider, STEPS quotient bits per stage, with the
// quotient saturated to all ones when it does not fit in Q_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_div #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 15,
  parameter int Q_W   = 22,
  parameter int SB_W  = 1,
  parameter int STEPS = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire logic             in_valid,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic [SB_W-1:0]  sb_in,
  output logic                  out_valid,
  output logic [Q_W-1:0]        quo,
  output logic [SB_W-1:0]       sb_out
);

  localparam int NS = (Q_W + STEPS - 1) / STEPS;
  localparam int HW = NUM_W - Q_W;
  localparam int CW = (HW > DEN_W) ? HW : DEN_W;

  logic             vld   [NS+1];
  logic             ovf   [NS+1];
  logic [DEN_W-1:0] rem   [NS+1];
  logic [DEN_W-1:0] den_r [NS+1];
  logic [Q_W-1:0]   quo_r [NS+1];
  logic [Q_W-1:0]   lo    [NS+1];
  logic [SB_W-1:0]  sb    [NS+1];

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;

  // upper numerator bits decide overflow and seed the remainder
  assign hi_ext  = CW'(num[NUM_W-1:Q_W]);
  assign den_ext = CW'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ovf[0]   <= (hi_ext >= den_ext);
      rem[0]   <= hi_ext[DEN_W-1:0];
      den_r[0] <= den;
      quo_r[0] <= '0;
      lo[0]    <= num[Q_W-1:0];
      sb[0]    <= sb_in;
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_stg
    logic [DEN_W-1:0] rem_c;
    logic [Q_W-1:0]   quo_c;
    logic [Q_W-1:0]   lo_c;
    logic [DEN_W:0]   t;

    // shift in one numerator bit, subtract when it fits
    always_comb begin
      rem_c = rem[s-1];
      quo_c = quo_r[s-1];
      lo_c  = lo[s-1];
      t     = '0;
      for (int j = 0; j < STEPS; j++) begin
        if ((s - 1) * STEPS + j < Q_W) begin
          t    = {rem_c, lo_c[Q_W-1]};
          lo_c = lo_c << 1;
          if (t >= {1'b0, den_r[s-1]}) begin
            t     = t - {1'b0, den_r[s-1]};
            quo_c = {quo_c[Q_W-2:0], 1'b1};
          end else begin
            quo_c = {quo_c[Q_W-2:0], 1'b0};
          end
          rem_c = t[DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ovf[s]   <= ovf[s-1];
        rem[s]   <= rem_c;
        den_r[s] <= den_r[s-1];
        quo_r[s] <= quo_c;
        lo[s]    <= lo_c;
        sb[s]    <= sb[s-1];
      end
    end
  end

  assign out_valid = vld[NS];
  assign quo       = ovf[NS] ? '1 : quo_r[NS];
  assign sb_out    = sb[NS];

endmodule

`default_nettype wire

[dv/rsd_checker.sv]
// ----------------------------------------------------------------------------
// rsd_checker
// Watches the sample and axis channels, predicts each result from the
// deadzone setting and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsd_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata,
  rsd_samp_if.snk          samp,
  rsd_axes_if.snk          axes,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } axes_t;

  axes_t       expected_axes[$];
  logic [11:0] deadzone_reg;

  // bitwise integer square root
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 30;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // scale one axis by nr / r with saturation
  function automatic logic signed [15:0] scale_axis(longint q, longint unsigned nr,
                                                    longint unsigned r);
    longint unsigned m;
    m = ((q < 0 ? -q : q) * nr) / r;
    if (m > rsd_pkg::AXIS_MAX) m = rsd_pkg::AXIS_MAX;
    return 16'(q < 0 ? -longint'(m) : longint'(m));
  endfunction

  function automatic axes_t predict_axes(logic [7:0] sx, logic [7:0] sy,
                                         logic [7:0] tr, logic [7:0] tl,
                                         logic [11:0] dz);
    axes_t           a;
    longint          xq, yq, diff;
    longint unsigned r, dq, nr, zmag;
    xq = (longint'(sx) - 128) * 128;
    yq = (longint'(sy) - 128) * 128;
    r = int_sqrt(xq * xq + yq * yq);
    dq = longint'(dz) * 4;
    a = '0;
    if (r != 0 && r >= dq) begin
      nr = ((r - dq) * rsd_pkg::ONE_Q) / (rsd_pkg::ONE_Q - dq);
      a.x = scale_axis(xq, nr, r);
      a.y = scale_axis(yq, nr, r);
    end
    diff = longint'(tr) - longint'(tl);
    zmag = ((diff < 0 ? -diff : diff) * rsd_pkg::ONE_Q) / 255;
    if (zmag > rsd_pkg::AXIS_MAX) zmag = rsd_pkg::AXIS_MAX;
    a.z = 16'(diff < 0 ? -longint'(zmag) : longint'(zmag));
    return a;
  endfunction

  assign pending = expected_axes.size();

  // track the register, queue predictions, compare results
  always @(posedge clk) begin
    axes_t e;
    if (rst) begin
      deadzone_reg <= '0;
      fail_count   <= 0;
    end else begin
      if (cfg_we) deadzone_reg <= cfg_wdata;
      if (samp.valid && samp.ready)
        expected_axes.push_back(predict_axes(samp.stick_x, samp.stick_y,
          samp.trigger_right, samp.trigger_left, deadzone_reg));
      if (axes.valid && axes.ready) begin
        if (expected_axes.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result x=%0d y=%0d z=%0d",
                     axes.axis_x, axes.axis_y, axes.axis_z);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_axes.pop_front();
          if (e.x !== axes.axis_x || e.y !== axes.axis_y || e.z !== axes.axis_z) begin
            if (fail_count < 10)
              $display("mismatch exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                       e.x, e.y, e.z, axes.axis_x, axes.axis_y, axes.axis_z);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives stick samples through several deadzone settings with random gaps
// on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [11:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          idle_cycles;

  rsd_samp_if samp ();
  rsd_axes_if axes ();

  radial_stick_deadzone uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .samp(samp.snk), .axes(axes.src)
  );

  rsd_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .samp(samp.snk), .axes(axes.snk), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, a few long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random result stalls, with quiet stretches
  initial begin
    int stall_mode;
    axes.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall_mode = $urandom_range(0, 9);
      axes.ready <= (stall_mode < 3) ? 1'b1 : ($urandom_range(0, 2) != 0);
      repeat ((stall_mode < 3) ? $urandom_range(20, 60) : 1) @(posedge clk);
      if (stall_mode == 9) begin
        axes.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no request accepted on either side
  always @(posedge clk) begin
    if (rst || (samp.valid && samp.ready) || (axes.valid && axes.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("radial_stick_deadzone verification failed");
      $finish;
    end
  end

  task automatic send_sample(logic [7:0] sx, logic [7:0] sy,
                             logic [7:0] tr, logic [7:0] tl, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      samp.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    samp.valid         <= 1'b1;
    samp.stick_x       <= sx;
    samp.stick_y       <= sy;
    samp.trigger_right <= tr;
    samp.trigger_left  <= tl;
    @(posedge clk);
    while (!samp.ready) @(posedge clk);
  endtask

  task automatic drain();
    samp.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_deadzone(logic [11:0] dz);
    cfg_we    <= 1'b1;
    cfg_wdata <= dz;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random sample, biased toward rim, centre and field extremes
  task automatic random_sample();
    logic [7:0] sx, sy;
    int         sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      sx = $urandom_range(0, 1) ? 8'd0 : 8'd255;
      sy = 8'($urandom);
    end else if (sel < 4) begin
      sx = 8'(128 + $urandom_range(0, 12) - 6);
      sy = 8'(128 + $urandom_range(0, 12) - 6);
    end else begin
      sx = 8'($urandom);
      sy = 8'($urandom);
    end
    send_sample(sx, sy, 8'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    logic [11:0] dz_list[6];
    logic [7:0]  edge_vals[5];
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    samp.valid       = 1'b0;
    samp.stick_x     = '0;
    samp.stick_y     = '0;
    samp.trigger_right = '0;
    samp.trigger_left  = '0;
    dz_list   = '{12'd0, 12'd4095, 12'd1024, 12'd1, 12'd2048, 12'd3500};
    edge_vals = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd255};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: centre, extremes, diagonals, trigger ends at deadzone 0
    foreach (edge_vals[i])
      foreach (edge_vals[j])
        if (i + j < 9 && (i == j || i == 0 || j == 4))
          send_sample(edge_vals[i], edge_vals[j], edge_vals[j], edge_vals[i], 1'b0);
    send_sample(8'd128, 8'd128, 8'd255, 8'd0, 1'b1);
    send_sample(8'd128, 8'd128, 8'd0, 8'd255, 1'b1);
    send_sample(8'd200, 8'd60, 8'd77, 8'd77, 1'b0);
    drain();

    // random phases across deadzone settings, extremes included
    foreach (dz_list[k]) begin
      set_deadzone(k == 5 ? 12'($urandom_range(0, 4095)) : dz_list[k]);
      // just off centre and at full x deflection
      send_sample(8'd128, 8'd129, 8'd0, 8'd0, 1'b0);
      send_sample(8'd255, 8'd128, 8'd1, 8'd0, 1'b0);
      repeat (145) random_sample();
      drain();
    end
    if (fail_count == 0)
      $display("radial_stick_deadzone verification clean");
    else
      $display("radial_stick_deadzone verification failed");
    $finish;
  end

endmodule

`default_nettype wire
